@@ hdl/srt_pkg.sv @@
// Package for the sorted route table: payload structs, command codes, sequencer states.
// No dependencies.
`default_nettype none
package srt_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] route_dest;
    logic [15:0] next_hop;
    logic [7:0]  hop_depth;
    logic        gateway_flag;
    logic [15:0] position;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] entry_dest;
    logic [15:0] entry_out;
    logic [7:0]  entry_depth;
    logic        entry_is_gateway;
    logic        was_dropped;
    logic [6:0]  entry_count;
    logic        gateway_valid;
    logic [15:0] gateway_dest;
    logic [15:0] gateway_out;
    logic [7:0]  gateway_depth;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dest;
    logic [15:0] link;
    logic [7:0]  depth;
    logic        gw;
  } route_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,   // issue read of entry at cnt
    ST_SRCH_CMP,  // compare read data
    ST_UPD,       // update matched entry
    ST_SH_RD,     // read entry cnt-1 for shift
    ST_SH_WR,     // compare/shift or insert
    ST_POST,      // gateway maintenance decision
    ST_RS_RD,
    ST_RS_CMP,
    ST_POS_RD,
    ST_POS_DATA,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

@@ hdl/sorted_route_table.sv @@
// Sorted route table top level: memory, sequencer, shared compare path.
// Depends on srt_pkg.
// Find searches the entries one by one and stops on a hit; read and next read one entry,
// next on an empty table none. Update searches, then shifts larger entries up to insert a
// new one, checks the gateway record and may rescan every entry for a new gateway.
// One transaction at a time; the next is accepted the cycle after the result leaves.
// Reset empties the table and sets the gateway record to none; no clearing pass.
`default_nettype none
module sorted_route_table (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire srt_pkg::in_item_t in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output srt_pkg::out_item_t out_data
);
  import srt_pkg::*;

  route_t mem [ENTRIES];
  route_t rd;
  logic [IDX_W-1:0] raddr, waddr;
  logic we;
  route_t wdata;

  state_t state, state_next;
  in_item_t req;
  logic [CNT_W-1:0] total, cnt;
  logic best_ok;
  logic [IDX_W-1:0] scan;
  logic scan_first;
  route_t gwrec, res;
  logic found, dropped, hit;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        unique case (cmd_t'(in_data.cmd))
          CMD_UPDATE, CMD_FIND: state_next = ST_SRCH_RD;
          CMD_READ: state_next = ST_POS_RD;
          CMD_NEXT: state_next = (total == '0) ? ST_OUT : ST_POS_RD;
        endcase
      end
      ST_SRCH_RD: state_next = (cnt == total) ?
        ((req.cmd == CMD_FIND) ? ST_OUT :
         (total == CNT_W'(ENTRIES)) ? ST_POST : ST_SH_RD) : ST_SRCH_CMP;
      ST_SRCH_CMP: state_next = (rd.dest == req.route_dest) ?
        ((req.cmd == CMD_FIND) ? ST_OUT : ST_UPD) : ST_SRCH_RD;
      ST_UPD: state_next = ST_POST;
      ST_SH_RD: state_next = ST_SH_WR;
      ST_SH_WR: state_next = (cnt != '0 && rd.dest > req.route_dest) ? ST_SH_RD : ST_POST;
      ST_POST: state_next = (!req.gateway_flag && gwrec.dest == req.route_dest) ?
        ST_RS_RD : ST_OUT;
      ST_RS_RD: state_next = (cnt == total) ? ST_OUT : ST_RS_CMP;
      ST_RS_CMP: state_next = ST_RS_RD;
      ST_POS_RD: state_next = ST_POS_DATA;
      ST_POS_DATA: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output and memory control
  always_comb begin
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    raddr = cnt[IDX_W-1:0];
    we = 1'b0;
    waddr = cnt[IDX_W-1:0];
    wdata = rd;
    unique case (state)
      ST_SH_RD: raddr = IDX_W'(cnt - 1'b1);
      ST_SH_WR: begin
        we = 1'b1;
        if (cnt != '0 && rd.dest > req.route_dest) wdata = rd;
        else wdata = '{req.route_dest, req.next_hop, req.hop_depth, req.gateway_flag};
      end
      ST_UPD: begin
        we = (req.hop_depth <= rd.depth);
        wdata = '{rd.dest, req.next_hop, req.hop_depth, req.gateway_flag};
      end
      ST_POS_RD: raddr = (req.cmd == CMD_READ) ? req.position[IDX_W-1:0] : scan;
      default: ;
    endcase
    out_data = '{found, res.dest, res.link, res.depth, res.gw, dropped,
                 7'(total), gwrec.gw, gwrec.dest, gwrec.link, gwrec.depth};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
      scan_first <= 1'b1;
      scan <= '0;
      gwrec <= '{16'hffff, 16'hffff, 8'hff, 1'b0};
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          req <= in_data;
          cnt <= '0;
          found <= 1'b0;
          dropped <= 1'b0;
          hit <= 1'b0;
          // next on an empty table returns the gateway record
          res <= (in_data.cmd == CMD_NEXT && total == '0) ? gwrec : '0;
          if (in_data.cmd == CMD_NEXT) begin
            if (total == '0) ;
            else if (!scan_first && CNT_W'(scan) + 1'b1 < total) scan <= scan + 1'b1;
            else scan <= '0;
            if (total != '0) scan_first <= 1'b0;
          end
        end
        ST_SRCH_RD: if (cnt == total) begin
          if (req.cmd == CMD_UPDATE && total == CNT_W'(ENTRIES)) dropped <= 1'b1;
        end
        ST_SRCH_CMP: if (rd.dest == req.route_dest) begin
          found <= 1'b1;
          hit <= 1'b1;
          res <= rd;
        end else cnt <= cnt + 1'b1;
        ST_UPD: if (req.hop_depth <= rd.depth)
          res <= '{rd.dest, req.next_hop, req.hop_depth, req.gateway_flag};
        ST_SH_WR: if (cnt != '0 && rd.dest > req.route_dest) cnt <= cnt - 1'b1;
        else begin
          found <= 1'b1;
          hit <= 1'b1;
          res <= '{req.route_dest, req.next_hop, req.hop_depth, req.gateway_flag};
          total <= total + 1'b1;
        end
        ST_POST: begin
          cnt <= '0;
          best_ok <= 1'b0;
          if (req.gateway_flag && gwrec.depth >= req.hop_depth) begin
            if (hit) gwrec <= res;
          end
        end
        ST_RS_RD: if (cnt == total) begin
          if (!best_ok) begin
            gwrec.gw <= 1'b0;
            gwrec.depth <= 8'hff;
          end
        end
        ST_RS_CMP: begin
          if (rd.gw && (!best_ok || gwrec.depth > rd.depth)) begin
            gwrec <= rd;
            best_ok <= 1'b1;
          end
          cnt <= cnt + 1'b1;
        end
        ST_POS_DATA: if (req.cmd == CMD_NEXT ||
                         (req.position < 16'(total))) begin
          found <= 1'b1;
          res <= rd;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for sorted_route_table: self-checking, with a behavioural route table predictor.
// Depends on srt_pkg and the sorted_route_table RTL.
`timescale 1ns / 1ps
module tb_top;
  import srt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  sorted_route_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  route_t    routes[ENTRIES];
  int        route_total;
  route_t    best_gw;
  int        scan_pos;
  bit        scan_fresh;
  out_item_t expected_results[$];

  int  fail_count;
  int  idle_cycles;
  bit  hold_receiver;
  bit  receiver_hold_done;
  int  narrow_keys;   // bias destinations into a small key space

  function automatic int find_route(logic [15:0] dest);
    for (int i = 0; i < route_total; i++)
      if (routes[i].dest == dest) return i;
    return -1;
  endfunction

  function automatic void rescan_best_gw();
    int best;
    best = -1;
    for (int i = 0; i < route_total; i++)
      if (routes[i].gw && (best < 0 || routes[best].depth > routes[i].depth)) best = i;
    if (best < 0) begin
      best_gw.gw = 1'b0;
      best_gw.depth = 8'hff;
    end else begin
      best_gw = routes[best];
    end
  endfunction

  function automatic out_item_t apply_route_cmd(in_item_t it);
    out_item_t r;
    route_t    e;
    int        idx;
    int        i;
    r = '0;
    e = '0;
    idx = -1;
    case (cmd_t'(it.cmd))
      CMD_UPDATE: begin
        idx = find_route(it.route_dest);
        if (idx >= 0) begin
          if (it.hop_depth <= routes[idx].depth) begin
            routes[idx].depth = it.hop_depth;
            routes[idx].link = it.next_hop;
            routes[idx].gw = it.gateway_flag;
          end
        end else if (route_total < ENTRIES) begin
          i = route_total - 1;
          while (i >= 0 && routes[i].dest > it.route_dest) begin
            routes[i + 1] = routes[i];
            i--;
          end
          idx = i + 1;
          routes[idx] = '{it.route_dest, it.next_hop, it.hop_depth, it.gateway_flag};
          route_total++;
        end else begin
          r.was_dropped = 1'b1;
        end
        if (idx >= 0) begin
          e = routes[idx];
          r.found = 1'b1;
        end
        if (it.gateway_flag && best_gw.depth >= it.hop_depth) begin
          if (idx >= 0) best_gw = routes[idx];
        end else if (!it.gateway_flag && best_gw.dest == it.route_dest) begin
          rescan_best_gw();
        end
      end
      CMD_FIND: begin
        idx = find_route(it.route_dest);
        if (idx >= 0) begin
          e = routes[idx];
          r.found = 1'b1;
        end
      end
      CMD_READ: begin
        if (it.position < route_total) begin
          e = routes[it.position];
          r.found = 1'b1;
        end
      end
      default: begin
        if (route_total > 0) begin
          scan_pos = scan_fresh ? 0 : (scan_pos + 1) % route_total;
          scan_fresh = 1'b0;
          e = routes[scan_pos];
          r.found = 1'b1;
        end else begin
          e = best_gw;
        end
      end
    endcase
    r.entry_dest = e.dest;
    r.entry_out = e.link;
    r.entry_depth = e.depth;
    r.entry_is_gateway = e.gw;
    r.entry_count = route_total[6:0];
    r.gateway_valid = best_gw.gw;
    r.gateway_dest = best_gw.dest;
    r.gateway_out = best_gw.link;
    r.gateway_depth = best_gw.depth;
    return r;
  endfunction

  // the gap is never empty, so a drive and its release never share an edge
  task automatic random_gap(int max_long);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_long)
                                    : $urandom_range(1, 2);
    repeat (n) @(posedge clk);
  endtask

  // one transaction; prediction made at acceptance
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_route_cmd(it));
    if ($urandom_range(0, 1)) begin
      in_valid <= 1'b0;
      random_gap(30);
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(cmd_t c, logic [15:0] dest, logic [15:0] link,
                                        logic [7:0] depth, logic gw, logic [15:0] pos);
    in_item_t it;
    it.cmd = c;
    it.route_dest = dest;
    it.next_hop = link;
    it.hop_depth = depth;
    it.gateway_flag = gw;
    it.position = pos;
    return it;
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t it;
    logic [15:0] dest;
    int k;
    k = $urandom_range(0, 99);
    dest = narrow_keys ? 16'($urandom_range(0, 90)) : 16'($urandom);
    if ($urandom_range(0, 19) == 0) dest = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    it = make_cmd(k < 45 ? CMD_UPDATE : k < 65 ? CMD_FIND : k < 82 ? CMD_READ : CMD_NEXT,
                  dest, 16'($urandom), 8'($urandom), 1'($urandom),
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 70)));
    // find on a known entry often enough to hit
    if (it.cmd == CMD_FIND && route_total > 0 && $urandom_range(0, 1))
      it.route_dest = routes[$urandom_range(0, route_total - 1)].dest;
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_cmd(CMD_NEXT, 16'h0, 16'h0, 8'h0, 1'b0, 16'h0));      // empty next
    send_item(make_cmd(CMD_FIND, 16'hffff, 16'h0, 8'h0, 1'b0, 16'h0));   // find miss
    send_item(make_cmd(CMD_READ, 16'h0, 16'h0, 8'h0, 1'b0, 16'hffff));   // out of range
    send_item(make_cmd(CMD_UPDATE, 16'h8000, 16'hffff, 8'hff, 1'b1, 16'hffff));
    send_item(make_cmd(CMD_UPDATE, 16'h0000, 16'h1234, 8'h10, 1'b1, 16'h0));
    send_item(make_cmd(CMD_UPDATE, 16'hffff, 16'h0000, 8'h00, 1'b0, 16'h0));
    send_item(make_cmd(CMD_UPDATE, 16'h4000, 16'haaaa, 8'h05, 1'b1, 16'h0));
    send_item(make_cmd(CMD_UPDATE, 16'h4000, 16'h5555, 8'h09, 1'b1, 16'h0)); // worse, kept
    send_item(make_cmd(CMD_UPDATE, 16'h4000, 16'h5555, 8'h05, 1'b0, 16'h0)); // flag lost: rescan
    send_item(make_cmd(CMD_UPDATE, 16'h0000, 16'h0001, 8'h10, 1'b0, 16'h0)); // rescan
    send_item(make_cmd(CMD_UPDATE, 16'h8000, 16'h0002, 8'h00, 1'b0, 16'h0)); // rescan to none
    send_item(make_cmd(CMD_FIND, 16'h4000, 16'h0, 8'h0, 1'b0, 16'h0));
    for (int i = 0; i < 5; i++) send_item(make_cmd(CMD_NEXT, 16'h0, 16'h0, 8'h0, 1'b0, 16'h0));
    for (int p = 0; p < 5; p++)
      send_item(make_cmd(CMD_READ, 16'h0, 16'h0, 8'h0, 1'b0, 16'(p)));
    wait_drained();
  endtask

  // fill to full, then offer gateway routes that are dropped, clear the best gateway's flag and read past the end
  task automatic test_full_table();
    while (route_total < ENTRIES)
      send_item(make_cmd(CMD_UPDATE, 16'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom), 16'h0));
    for (int i = 0; i < 6; i++)
      send_item(make_cmd(CMD_UPDATE, 16'($urandom), 16'($urandom), 8'(i), 1'b1, 16'h0));
    send_item(make_cmd(CMD_UPDATE, best_gw.dest, 16'h0, 8'h00, 1'b0, 16'h0));
    send_item(make_cmd(CMD_READ, 16'h0, 16'h0, 8'h0, 1'b0, 16'(ENTRIES - 1)));
    send_item(make_cmd(CMD_READ, 16'h0, 16'h0, 8'h0, 1'b0, 16'(ENTRIES)));
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    for (int i = 0; i < 20; i++) send_item(rand_cmd());
    wait (receiver_hold_done);
    hold_receiver = 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) narrow_keys = $urandom_range(0, 2) != 0;
      send_item(rand_cmd());
    end
    wait_drained();
  endtask

  // receiver
  initial begin
    out_stall = 1'b0;
    receiver_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver && !receiver_hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        receiver_hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        random_gap(40);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        out_item_t x;
        x = expected_results.pop_front();
        if (x.found !== out_data.found) begin
          $error("found exp %0h got %0h", x.found, out_data.found); fail_count++; end
        if (x.entry_dest !== out_data.entry_dest) begin
          $error("entry_dest exp %0h got %0h", x.entry_dest, out_data.entry_dest);
          fail_count++; end
        if (x.entry_out !== out_data.entry_out) begin
          $error("entry_out exp %0h got %0h", x.entry_out, out_data.entry_out);
          fail_count++; end
        if (x.entry_depth !== out_data.entry_depth) begin
          $error("entry_depth exp %0h got %0h", x.entry_depth, out_data.entry_depth);
          fail_count++; end
        if (x.entry_is_gateway !== out_data.entry_is_gateway) begin
          $error("entry_is_gateway exp %0h got %0h", x.entry_is_gateway,
                 out_data.entry_is_gateway); fail_count++; end
        if (x.was_dropped !== out_data.was_dropped) begin
          $error("was_dropped exp %0h got %0h", x.was_dropped, out_data.was_dropped);
          fail_count++; end
        if (x.entry_count !== out_data.entry_count) begin
          $error("entry_count exp %0d got %0d", x.entry_count, out_data.entry_count);
          fail_count++; end
        if (x.gateway_valid !== out_data.gateway_valid) begin
          $error("gateway_valid exp %0h got %0h", x.gateway_valid, out_data.gateway_valid);
          fail_count++; end
        if (x.gateway_dest !== out_data.gateway_dest) begin
          $error("gateway_dest exp %0h got %0h", x.gateway_dest, out_data.gateway_dest);
          fail_count++; end
        if (x.gateway_out !== out_data.gateway_out) begin
          $error("gateway_out exp %0h got %0h", x.gateway_out, out_data.gateway_out);
          fail_count++; end
        if (x.gateway_depth !== out_data.gateway_depth) begin
          $error("gateway_depth exp %0h got %0h", x.gateway_depth, out_data.gateway_depth);
          fail_count++; end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    hold_receiver = 1'b0;
    narrow_keys = 1;
    route_total = 0;
    best_gw = '{16'hffff, 16'hffff, 8'hff, 1'b0};
    scan_pos = 0;
    scan_fresh = 1'b1;
    for (int i = 0; i < ENTRIES; i++) routes[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1500);
    test_full_table();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
